// ===== sv/dkf_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth Kalman filter package
// Shared widths, memory map, datapath term and write-back types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dkf_pkg;

  localparam int RAM_DEPTH = 32;
  localparam int RAM_AW    = 5;
  localparam int DATA_W    = 32;
  localparam int F_FRAC    = 16;
  localparam int RECIP_FRAC = 23;

  localparam logic [RAM_AW-1:0] MEAN_BASE = 5'd0;
  localparam logic [RAM_AW-1:0] COV_BASE  = 5'd3;
  localparam logic [RAM_AW-1:0] A_BASE    = 5'd12;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_F    = 2'd1,
    SH_R    = 2'd2,
    SH_C    = 2'd3
  } shift_t;

  typedef enum logic [1:0] {
    DST_RAM  = 2'd0,
    DST_GAIN = 2'd1,
    DST_OUT  = 2'd2
  } dst_t;

  typedef struct packed {
    logic               vld;
    logic signed [32:0] opa;
    logic               use_y;
    shift_t             sh;
    logic               neg;
    logic               first;
    logic               last;
    logic signed [32:0] init;
    dst_t               kind;
    logic [RAM_AW-1:0]  dst;
  } term_t;

  typedef struct packed {
    logic               vld;
    dst_t               kind;
    logic [RAM_AW-1:0]  dst;
    logic signed [31:0] data;
    logic               clip;
  } wb_t;

endpackage

`default_nettype wire

// ===== sv/dkf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dkf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/dkf_div.sv =====
// ----------------------------------------------------------------------------
// Depth Kalman filter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dkf_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_r;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem, num_r[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      num_r <= num;
      quo   <= '0;
      cnt   <= CW'(NUM_W - 1);
    end else if (busy) begin
      if (qbit) begin
        rem <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo   <= {quo[NUM_W-2:0], qbit};
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dkf_mac.sv =====
// ----------------------------------------------------------------------------
// Depth Kalman filter multiply-accumulate pipeline
// Multiply, round and shift where a shift is selected, and accumulate, then saturate to 32 bits on the last term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dkf_mac #(
  parameter int COV_FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dkf_pkg::term_t     term,
  input  wire logic signed [31:0] rdata,
  input  wire logic signed [31:0] y,
  output dkf_pkg::wb_t            wb
);

  localparam logic signed [67:0] HALF_F = 68'sd1 <<< (dkf_pkg::F_FRAC - 1);
  localparam logic signed [67:0] HALF_R = 68'sd1 <<< (dkf_pkg::RECIP_FRAC - 1);
  localparam logic signed [67:0] HALF_C = 68'sd1 <<< (COV_FRAC_BITS - 1);
  localparam logic signed [67:0] MAX32  = 68'sd2147483647;
  localparam logic signed [67:0] MIN32  = -68'sd2147483648;

  dkf_pkg::term_t     d1, d2, d3;
  logic signed [64:0] prod;
  logic signed [67:0] acc;
  logic signed [32:0] opb;
  logic signed [67:0] pe, rnd, base, addend, init_ext;

  always_comb begin
    opb = d1.use_y ? {y[31], y} : {rdata[31], rdata};
  end

  always_comb begin
    pe       = $signed({{3{prod[64]}}, prod});
    init_ext = $signed({{35{d2.init[32]}}, d2.init});
    case (d2.sh)
      dkf_pkg::SH_NONE: rnd = pe;
      dkf_pkg::SH_F:    rnd = (pe + HALF_F) >>> dkf_pkg::F_FRAC;
      dkf_pkg::SH_R:    rnd = (pe + HALF_R) >>> dkf_pkg::RECIP_FRAC;
      dkf_pkg::SH_C:    rnd = (pe + HALF_C) >>> COV_FRAC_BITS;
      default:          rnd = pe;
    endcase
    base   = d2.first ? init_ext : acc;
    addend = d2.neg ? -rnd : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
      d3 <= '0;
    end else begin
      d1 <= term;
      d2 <= d1;
      d3 <= d2;
    end
  end

  always_ff @(posedge clk) begin
    prod <= d1.opa * opb;
    if (d2.vld) begin
      acc <= base + addend;
    end
  end

  always_comb begin
    wb.vld  = d3.vld & d3.last;
    wb.kind = d3.kind;
    wb.dst  = d3.dst;
    if (acc > MAX32) begin
      wb.data = 32'sh7fffffff;
      wb.clip = 1'b1;
    end else if (acc < MIN32) begin
      wb.data = 32'sh80000000;
      wb.clip = 1'b1;
    end else begin
      wb.data = acc[31:0];
      wb.clip = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/depth_kalman_filter_3state.sv =====
// ----------------------------------------------------------------------------
// Depth Kalman filter, three states
// Constant-acceleration filter with a scalar depth measurement.
// ----------------------------------------------------------------------------
// Usage: each beat on the s_axis channel is one item; tuser selects init (0)
// or predict-and-correct (1). Each item gives exactly one beat on m_axis.
// The mean and covariance live in a small RAM; a sequencer feeds a single
// multiply-accumulate pipeline term by term and writes results back.
// An init writes the state RAM and reads out the result. When the innovation
// variance is positive, an update runs 94 multiply-accumulate terms through
// the one shared multiplier, lets the pipeline drain between phases and runs
// a restoring divider for COV_FRAC_BITS+24 quotient bits; else it skips the
// correction. One item is in work at a time.
// The result sits in an output register; the next item is accepted while it
// waits, and the block holds its next result until the register is free.
// Reset clears the state to zero and the configuration registers to their
// defaults. Configuration is written through cfg_we, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_kalman_filter_3state #(
  parameter int COV_FRAC_BITS = 24
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [55:0]  s_axis_tdata,   // depth_meas, dt
  input  wire logic [0:0]   s_axis_tuser,   // cmd
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,   // est_depth, est_velocity, est_accel,
                                            // depth_variance, zero pad
  output logic      [0:0]   m_axis_tuser,   // saturated
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int NUM_W = COV_FRAC_BITS + 24;

  localparam logic [2:0] REG_QD = 3'd0;
  localparam logic [2:0] REG_QV = 3'd1;
  localparam logic [2:0] REG_QA = 3'd2;
  localparam logic [2:0] REG_RD = 3'd3;
  localparam logic [2:0] REG_SD = 3'd4;
  localparam logic [2:0] REG_SV = 3'd5;
  localparam logic [2:0] REG_SA = 3'd6;

  localparam logic cmd_init = 1'b0;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PREP  = 8'b00000010,
    S_INIT  = 8'b00000100,
    S_ISSUE = 8'b00001000,
    S_DRAIN = 8'b00010000,
    S_CHK   = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  typedef enum logic [6:0] {
    PH_A    = 7'b0000001,
    PH_P    = 7'b0000010,
    PH_MP   = 7'b0000100,
    PH_GAIN = 7'b0001000,
    PH_MEAN = 7'b0010000,
    PH_COV  = 7'b0100000,
    PH_OUT  = 7'b1000000
  } phase_t;

  state_t st;
  phase_t ph;

  logic [30:0] qn0, qn1, qn2, rn, sv0, sv1, sv2;

  logic               cmd_r;
  logic signed [31:0] z_r;
  logic [23:0]        dt_r;
  logic [31:0]        half_r;
  logic [47:0]        dt_sq;
  logic [48:0]        dt_sq_rnd;

  logic [1:0] oi, oj, tk, dcnt;
  logic [1:0] rmax, cmax, tmax;
  logic [3:0] init_cnt;
  logic [1:0] row;

  logic signed [31:0] gain_r [3];
  logic signed [31:0] mean_o [3];
  logic signed [31:0] var_r;
  logic signed [31:0] p00, mp0, y_r, recip_r;
  logic               flag;

  dkf_pkg::term_t term;
  dkf_pkg::wb_t   wb;

  logic [dkf_pkg::RAM_AW-1:0] raddr, waddr;
  logic [31:0]                ram_q, wdata;
  logic                       we;
  logic [dkf_pkg::RAM_DEPTH-1:0] valid_q;
  logic                       rd_valid;
  logic signed [31:0]         rdata_eff;

  logic signed [33:0] s_val;
  logic               s_pos;
  logic signed [32:0] diff;
  logic signed [31:0] y_sat;
  logic               y_clip;
  logic               div_start, div_busy, div_done;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic               recip_clip;
  logic               out_free;

  function automatic logic [3:0] lin3(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic signed [32:0] f_elem(input logic [1:0] r, input logic [1:0] c,
                                                input logic [23:0] dt,
                                                input logic [31:0] half);
    logic signed [32:0] v;
    v = '0;
    if (r == c) begin
      v = 33'sd65536;
    end else if (c == r + 2'd1) begin
      v = $signed({9'b0, dt});
    end else if (r == 2'd0 && c == 2'd2) begin
      v = $signed({1'b0, half});
    end
    return v;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      qn0 <= 31'd167772;
      qn1 <= 31'd167772;
      qn2 <= 31'd1677722;
      rn  <= 31'd335544;
      sv0 <= 31'd335544;
      sv1 <= 31'd167772;
      sv2 <= 31'd167772;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QD:  qn0 <= cfg_data;
        REG_QV:  qn1 <= cfg_data;
        REG_QA:  qn2 <= cfg_data;
        REG_RD:  rn  <= cfg_data;
        REG_SD:  sv0 <= cfg_data;
        REG_SV:  sv1 <= cfg_data;
        REG_SA:  sv2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (st == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    dt_sq     = dt_r * dt_r;
    dt_sq_rnd = {1'b0, dt_sq} + 49'h10000;
  end

  // Sequencer limits per phase.
  always_comb begin
    rmax = (ph == PH_OUT) ? 2'd3 : 2'd2;
    cmax = (ph == PH_A || ph == PH_P || ph == PH_COV) ? 2'd2 : 2'd0;
    case (ph)
      PH_A, PH_P, PH_MP: tmax = 2'd2;
      PH_MEAN, PH_COV:   tmax = 2'd1;
      default:           tmax = 2'd0;
    endcase
    row = (ph == PH_COV) ? 2'd2 - oi : oi;
  end

  // Term generation.
  always_comb begin
    term       = '0;
    raddr      = dkf_pkg::MEAN_BASE;
    term.vld   = (st == S_ISSUE);
    term.sh    = dkf_pkg::SH_F;
    term.kind  = dkf_pkg::DST_RAM;
    term.first = (tk == 2'd0);
    term.last  = (tk == tmax);
    case (ph)
      PH_A: begin
        raddr    = dkf_pkg::COV_BASE + {1'b0, lin3(tk, oj)};
        term.opa = f_elem(row, tk, dt_r, half_r);
        term.dst = dkf_pkg::A_BASE + {1'b0, lin3(row, oj)};
      end
      PH_P: begin
        raddr    = dkf_pkg::A_BASE + {1'b0, lin3(row, tk)};
        term.opa = f_elem(oj, tk, dt_r, half_r);
        if (row == oj) begin
          case (row)
            2'd0:    term.init = $signed({2'b00, qn0});
            2'd1:    term.init = $signed({2'b00, qn1});
            default: term.init = $signed({2'b00, qn2});
          endcase
        end
        term.dst = dkf_pkg::COV_BASE + {1'b0, lin3(row, oj)};
      end
      PH_MP: begin
        raddr    = dkf_pkg::MEAN_BASE + {3'b000, tk};
        term.opa = f_elem(row, tk, dt_r, half_r);
        term.dst = dkf_pkg::MEAN_BASE + {3'b000, row};
      end
      PH_GAIN: begin
        raddr     = dkf_pkg::COV_BASE + {1'b0, lin3(row, 2'd0)};
        term.opa  = {recip_r[31], recip_r};
        term.sh   = dkf_pkg::SH_R;
        term.kind = dkf_pkg::DST_GAIN;
        term.dst  = {3'b000, row};
      end
      PH_MEAN: begin
        raddr = dkf_pkg::MEAN_BASE + {3'b000, row};
        if (tk == 2'd0) begin
          term.opa = 33'sd1;
          term.sh  = dkf_pkg::SH_NONE;
        end else begin
          term.opa   = {gain_r[row][31], gain_r[row]};
          term.use_y = 1'b1;
          term.sh    = dkf_pkg::SH_C;
        end
        term.dst = dkf_pkg::MEAN_BASE + {3'b000, row};
      end
      PH_COV: begin
        if (tk == 2'd0) begin
          raddr    = dkf_pkg::COV_BASE + {1'b0, lin3(row, oj)};
          term.opa = 33'sd1;
          term.sh  = dkf_pkg::SH_NONE;
        end else begin
          raddr    = dkf_pkg::COV_BASE + {1'b0, lin3(2'd0, oj)};
          term.opa = {gain_r[row][31], gain_r[row]};
          term.sh  = dkf_pkg::SH_C;
          term.neg = 1'b1;
        end
        term.dst = dkf_pkg::COV_BASE + {1'b0, lin3(row, oj)};
      end
      PH_OUT: begin
        raddr     = (oi == 2'd3) ? dkf_pkg::COV_BASE : dkf_pkg::MEAN_BASE + {3'b000, oi};
        term.opa  = 33'sd1;
        term.sh   = dkf_pkg::SH_NONE;
        term.kind = dkf_pkg::DST_OUT;
        term.dst  = {3'b000, oi};
      end
      default: ;
    endcase
  end

  // RAM write port is shared between the init sweep and write-back.
  always_comb begin
    if (st == S_INIT) begin
      we    = 1'b1;
      waddr = {1'b0, init_cnt};
      case (init_cnt)
        4'd0:    wdata = z_r;
        4'd3:    wdata = {1'b0, sv0};
        4'd7:    wdata = {1'b0, sv1};
        4'd11:   wdata = {1'b0, sv2};
        default: wdata = '0;
      endcase
    end else begin
      we    = wb.vld && (wb.kind == dkf_pkg::DST_RAM);
      waddr = wb.dst;
      wdata = wb.data;
    end
  end

  dkf_ram #(
    .WIDTH (dkf_pkg::DATA_W),
    .DEPTH (dkf_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      rd_valid <= valid_q[raddr];
    end
  end

  assign rdata_eff = rd_valid ? $signed(ram_q) : 32'sd0;

  dkf_mac #(
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .term  (term),
    .rdata (rdata_eff),
    .y     (y_r),
    .wb    (wb)
  );

  // Innovation variance, innovation and divider.
  always_comb begin
    s_val  = $signed({{2{p00[31]}}, p00}) + $signed({3'b000, rn});
    s_pos  = !s_val[33] && (s_val != 34'sd0);
    diff   = $signed({z_r[31], z_r}) - $signed({mp0[31], mp0});
    y_clip = 1'b0;
    if (diff > 33'sd2147483647) begin
      y_sat  = 32'sh7fffffff;
      y_clip = 1'b1;
    end else if (diff < -33'sd2147483648) begin
      y_sat  = 32'sh80000000;
      y_clip = 1'b1;
    end else begin
      y_sat = diff[31:0];
    end
    div_start  = (st == S_CHK) && s_pos;
    div_num    = (NUM_W'(1) << (COV_FRAC_BITS + dkf_pkg::RECIP_FRAC))
               + NUM_W'(s_val[33:1]);
    recip_clip = (div_quo[NUM_W-1:31] != '0);
  end

  dkf_div #(
    .NUM_W (NUM_W),
    .DEN_W (33)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s_val[32:0]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      ph       <= PH_OUT;
      oi       <= '0;
      oj       <= '0;
      tk       <= '0;
      dcnt     <= '0;
      init_cnt <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            st <= S_PREP;
          end
        end
        S_PREP: begin
          oi <= '0;
          oj <= '0;
          tk <= '0;
          if (cmd_r == cmd_init) begin
            init_cnt <= '0;
            st       <= S_INIT;
          end else begin
            ph <= PH_A;
            st <= S_ISSUE;
          end
        end
        S_INIT: begin
          if (init_cnt == 4'd11) begin
            ph <= PH_OUT;
            st <= S_ISSUE;
          end else begin
            init_cnt <= init_cnt + 4'd1;
          end
        end
        S_ISSUE: begin
          if (tk == tmax) begin
            tk <= '0;
            if (oj == cmax) begin
              oj <= '0;
              if (oi == rmax) begin
                oi   <= '0;
                dcnt <= 2'd2;
                st   <= S_DRAIN;
              end else begin
                oi <= oi + 2'd1;
              end
            end else begin
              oj <= oj + 2'd1;
            end
          end else begin
            tk <= tk + 2'd1;
          end
        end
        S_DRAIN: begin
          if (dcnt == 2'd0) begin
            case (ph)
              PH_A:    begin ph <= PH_P;    st <= S_ISSUE; end
              PH_P:    begin ph <= PH_MP;   st <= S_ISSUE; end
              PH_MP:   st <= S_CHK;
              PH_GAIN: begin ph <= PH_MEAN; st <= S_ISSUE; end
              PH_MEAN: begin ph <= PH_COV;  st <= S_ISSUE; end
              PH_COV:  begin ph <= PH_OUT;  st <= S_ISSUE; end
              PH_OUT:  st <= S_FIN;
              default: st <= S_FIN;
            endcase
          end else begin
            dcnt <= dcnt - 2'd1;
          end
        end
        S_CHK: begin
          if (s_pos) begin
            st <= S_DIV;
          end else begin
            ph <= PH_OUT;
            st <= S_ISSUE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ph <= PH_GAIN;
            st <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Item capture, intermediates and write-back taps.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_r <= s_axis_tuser[0];
      z_r   <= $signed(s_axis_tdata[31:0]);
      dt_r  <= s_axis_tdata[55:32];
    end
    if (st == S_PREP) begin
      half_r <= dt_sq_rnd[48:17];
    end
    if (st == S_CHK) begin
      y_r <= y_sat;
    end
    if (st == S_DIV && div_done) begin
      recip_r <= recip_clip ? 32'sh7fffffff : $signed(div_quo[31:0]);
    end
    if (wb.vld) begin
      case (wb.kind)
        dkf_pkg::DST_GAIN: gain_r[wb.dst[1:0]] <= wb.data;
        dkf_pkg::DST_OUT: begin
          if (wb.dst[1:0] == 2'd3) begin
            var_r <= wb.data;
          end else begin
            mean_o[wb.dst[1:0]] <= wb.data;
          end
        end
        dkf_pkg::DST_RAM: begin
          if (ph == PH_P && wb.dst == dkf_pkg::COV_BASE) begin
            p00 <= wb.data;
          end
          if (ph == PH_MP && wb.dst == dkf_pkg::MEAN_BASE) begin
            mp0 <= wb.data;
          end
        end
        default: ;
      endcase
    end
  end

  // Saturation flag for the item in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      flag <= 1'b0;
    end else begin
      if (wb.vld && wb.clip) begin
        flag <= 1'b1;
      end
      if (st == S_CHK && s_pos && y_clip) begin
        flag <= 1'b1;
      end
      if (st == S_DIV && div_done && recip_clip) begin
        flag <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (st == S_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FIN && out_free) begin
      m_axis_tdata[31:0]   <= mean_o[0];
      m_axis_tdata[63:32]  <= mean_o[1];
      m_axis_tdata[95:64]  <= mean_o[2];
      m_axis_tdata[126:96] <= var_r[31] ? 31'd0 : var_r[30:0];
      m_axis_tdata[127]    <= 1'b0;
      m_axis_tuser[0]      <= flag | var_r[31];
    end
  end

  ast_gain_phase: assert property (@(posedge clk) disable iff (rst)
    (wb.vld && wb.kind == dkf_pkg::DST_GAIN) |-> ph == PH_GAIN)
    else $error("gain write-back outside the gain phase");

  ast_init_quiet: assert property (@(posedge clk) disable iff (rst)
    st == S_INIT |-> !wb.vld)
    else $error("pipeline write-back during the init sweep");

  ast_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> st == S_PREP)
    else $error("accepted beat not taken into preparation");

  ast_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN && m_axis_tvalid && !m_axis_tready) |=> st == S_FIN)
    else $error("result overran a pending output beat");

  ast_div_idle: assert property (@(posedge clk) disable iff (rst)
    st == S_ISSUE |-> !div_busy)
    else $error("terms issued while the divider is busy");

endmodule

`default_nettype wire

// ===== tb/tb_depth_kalman_filter_3state.sv =====
// ----------------------------------------------------------------------------
// Depth Kalman filter testbench
// Drives init and update beats through the stream input, predicts each
// filter step in fixed point and compares every output beat field by field,
// across several register settings and with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_kalman_filter_3state;

  localparam bit CMD_INIT   = 1'b0;
  localparam bit CMD_UPDATE = 1'b1;

  localparam int REG_Q_DEPTH   = 0;
  localparam int REG_Q_VEL     = 1;
  localparam int REG_Q_ACCEL   = 2;
  localparam int REG_R_DEPTH   = 3;
  localparam int REG_P0_DEPTH  = 4;
  localparam int REG_P0_VEL    = 5;
  localparam int REG_P0_ACCEL  = 6;
  localparam int REG_UNUSED    = 7;
  localparam int NUM_REGS      = 7;

  localparam int COV_FRAC   = 24;
  localparam int MEAN_FRAC  = 16;

  typedef struct {
    bit                 cmd;
    logic signed [31:0] z;
    logic [23:0]        dt;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic signed [31:0] vel;
    logic signed [31:0] accel;
    logic [30:0]        var_depth;
    logic               sat;
  } est_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;

  depth_kalman_filter_3state dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  meas_t meas_queue[$];
  est_t  est_queue[$];

  bit [30:0] noise_regs[NUM_REGS];
  int        filt_mean[3];
  int        filt_cov[9];
  bit        clipped;

  int  idle_pct = 10;
  bit  hold_off = 1'b0;
  bit  start_hold = 1'b0;
  int  mismatches = 0;
  int  errors = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int n);
    if (n == 0) return v;
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic filter_step(meas_t m);
    longint f[9], a[9], p[9], mp[3], g[3];
    longint acc, s, recip, y, dtl;
    est_t   e;
    clipped = 1'b0;
    if (m.cmd == CMD_INIT) begin
      filt_mean[0] = m.z;
      filt_mean[1] = 0;
      filt_mean[2] = 0;
      for (int i = 0; i < 9; i++) filt_cov[i] = 0;
      filt_cov[0] = int'(noise_regs[REG_P0_DEPTH]);
      filt_cov[4] = int'(noise_regs[REG_P0_VEL]);
      filt_cov[8] = int'(noise_regs[REG_P0_ACCEL]);
    end else begin
      dtl = longint'(m.dt);
      f = '{65536, dtl, round_shift(dtl * dtl, 17), 0, 65536, dtl, 0, 0, 65536};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += round_shift(f[i*3+k] * longint'(filt_cov[k*3+j]), 16);
          a[i*3+j] = clip32(acc);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = (i == j) ? longint'(noise_regs[i]) : 0;
          for (int k = 0; k < 3; k++)
            acc += round_shift(a[i*3+k] * f[j*3+k], 16);
          p[i*3+j] = clip32(acc);
        end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += round_shift(f[i*3+k] * longint'(filt_mean[k]), 16);
        mp[i] = clip32(acc);
      end
      s = p[0] + longint'(noise_regs[REG_R_DEPTH]);
      if (s > 0) begin
        recip = clip32(((longint'(1) << 47) + s / 2) / s);
        y = clip32(longint'(m.z) - mp[0]);
        for (int i = 0; i < 3; i++)
          g[i] = clip32(round_shift(p[i*3] * recip, 23));
        for (int i = 0; i < 3; i++)
          filt_mean[i] = int'(clip32(mp[i] + round_shift(g[i] * y, COV_FRAC)));
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            filt_cov[i*3+j] = int'(clip32(p[i*3+j] - round_shift(g[i] * p[j], COV_FRAC)));
      end else begin
        for (int i = 0; i < 3; i++) filt_mean[i] = int'(mp[i]);
        for (int i = 0; i < 9; i++) filt_cov[i] = int'(p[i]);
      end
    end
    e.depth = filt_mean[0];
    e.vel   = filt_mean[1];
    e.accel = filt_mean[2];
    if (filt_cov[0] < 0) begin
      clipped = 1'b1;
      e.var_depth = '0;
    end else begin
      e.var_depth = filt_cov[0][30:0];
    end
    e.sat = clipped;
    est_queue.push_back(e);
  endtask

  // Input side: a beat stays offered until taken.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) filter_step(meas_queue.pop_front());
      if (s_axis_tvalid && !s_axis_tready) offer = 1'b1;
      else offer = meas_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct;
      s_axis_tvalid <= offer;
      if (offer) begin
        s_axis_tdata <= {meas_queue[0].dt, meas_queue[0].z};
        s_axis_tuser <= meas_queue[0].cmd;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && $urandom_range(0, 99) >= idle_pct;
  end

  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (800) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    est_t e;
    est_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.depth     = m_axis_tdata[31:0];
      got.vel       = m_axis_tdata[63:32];
      got.accel     = m_axis_tdata[95:64];
      got.var_depth = m_axis_tdata[126:96];
      got.sat       = m_axis_tuser[0];
      if (est_queue.size() == 0) begin
        errors++;
        $display("Output beat with no estimate pending: %h", m_axis_tdata);
      end else begin
        e = est_queue.pop_front();
        if (got !== e) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Estimate mismatch: expected %0d %0d %0d var %0d sat %0d, got %0d %0d %0d var %0d sat %0d",
                     e.depth, e.vel, e.accel, e.var_depth, e.sat,
                     got.depth, got.vel, got.accel, got.var_depth, got.sat);
        end
      end
    end
  end

  task automatic write_reg(int idx, bit [30:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data  <= val;
    if (idx < NUM_REGS) noise_regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_meas(bit cmd, logic signed [31:0] z, logic [23:0] dt);
    meas_t m;
    m.cmd = cmd;
    m.z   = z;
    m.dt  = dt;
    meas_queue.push_back(m);
  endtask

  task automatic drain;
    while (meas_queue.size() > 0 || est_queue.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_run(int count);
    int track;
    int roll;
    track = $urandom_range(0, 2000) << MEAN_FRAC;
    push_meas(CMD_INIT, track, 24'($urandom));
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        track = $urandom_range(0, 2000) << MEAN_FRAC;
        push_meas(CMD_INIT, track, 24'($urandom));
      end else if (roll < 15) begin
        push_meas(1'($urandom_range(0, 1)), $urandom, 24'($urandom));
      end else begin
        track += $urandom_range(0, 40000) - 20000;
        push_meas(CMD_UPDATE, track + $urandom_range(0, 8000) - 4000,
                  24'($urandom_range(1, 24'h20000)));
      end
    end
  endtask

  initial begin
    noise_regs = '{167772, 167772, 1677722, 335544, 335544, 167772, 167772};
    for (int i = 0; i < 9; i++) filt_cov[i] = 0;
    for (int i = 0; i < 3; i++) filt_mean[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Defaults from reset: extremes and an update ahead of any init.
    push_meas(CMD_UPDATE, 32'sh7fffffff, 24'hffffff);
    push_meas(CMD_INIT, 32'sh80000000, 24'h0);
    push_meas(CMD_UPDATE, 32'sh7fffffff, 24'h0);
    push_meas(CMD_UPDATE, 32'sh0, 24'h1);
    push_meas(CMD_INIT, 32'sh7fffffff, 24'hffffff);
    push_meas(CMD_UPDATE, -32'sd1, 24'h010000);
    push_meas(CMD_UPDATE, 32'sh80000000, 24'hffffff);
    push_meas(CMD_INIT, 32'sh0, 24'h0);
    for (int i = 1; i <= 6; i++) push_meas(CMD_UPDATE, i << 16, 24'h008000);
    drain();

    // Zero noise and zero start variance: the correction is skipped.
    for (int i = 0; i <= REG_UNUSED; i++) write_reg(i, 31'h0);
    push_meas(CMD_INIT, 32'sh00050000, 24'h0);
    push_meas(CMD_UPDATE, 32'sh00060000, 24'h0);
    push_meas(CMD_UPDATE, 32'sh00070000, 24'h010000);
    drain();

    // Largest registers in every slot, to drive the saturation paths.
    for (int i = 0; i <= REG_UNUSED; i++) write_reg(i, 31'h7fffffff);
    push_meas(CMD_UPDATE, 32'sh00010000, 24'h010000);
    push_meas(CMD_INIT, 32'sh00100000, 24'h0);
    push_meas(CMD_UPDATE, -32'sh00100000, 24'hffffff);
    push_meas(CMD_UPDATE, 32'sh0, 24'h000100);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(i, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 1 << 25)));
      idle_pct = (phase == 1) ? 0 : 10;
      if (phase == 2) start_hold = 1'b1;
      random_run(220);
      if (phase == 2) begin
        drain();
        write_reg(REG_R_DEPTH, 31'($urandom_range(0, 1 << 22)));
        push_meas(CMD_UPDATE, $urandom, 24'($urandom_range(1, 24'h10000)));
      end
      drain();
    end

    drain();
    if (errors == 0 && est_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
